[hdl/pnm_header_parser_unit_macros.svh]
// assertion macros used by the header parser checker
`ifndef PNM_HEADER_PARSER_UNIT_MACROS_SVH
`define PNM_HEADER_PARSER_UNIT_MACROS_SVH

// same-cycle implication, checked on every rising clock outside reset
`define PNMHP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked on every rising clock outside reset
`define PNMHP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/pnmhp_pkg.sv]
// types and constants for the netpbm header parser
package pnmhp_pkg;

    // width of the result fields and default width of the dimension accumulators
    localparam int unsigned FIELD_W      = 15;
    localparam int unsigned DIM_BITS_DEF = 15;

    // header characters
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // status codes
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_MAGIC = 1'b1;

    // one input beat
    typedef struct packed {
        logic [7:0] byte_value;
        logic       frame_start;
    } in_beat_t;

    // one result beat
    typedef struct packed {
        logic [FIELD_W-1:0] width;
        logic [FIELD_W-1:0] height;
        logic               status;
    } out_beat_t;

endpackage

[hdl/pnm_header_parser_unit.sv]
// top level of the netpbm header parser
// Parses a binary PGM/PPM header one byte per beat: magic bytes, an optional
// comment line, the width/height line, an optional comment line and the maxval
// line. While in_stall is low, one byte is accepted every cycle; the phase and
// both dimension accumulators update in the cycle the byte is accepted, and the
// line feed closing the maxval line (or, at byte 1, a bad magic byte) puts
// one result into the output register. A second result register absorbs one
// result while the output is stalled; in_stall rises only once that register
// is also full. The magic digit ('5' or '6') comes from format_kind, written
// over the cfg channel; the user must write it only while no header is in
// flight, as the block does not enforce this. After a result, bytes are dropped
// until a beat with frame_start set; the first byte after reset counts as
// byte 0. Width and height saturate at 2^DIM_BITS-1 and leave on 15-bit fields.
module pnm_header_parser_unit #(
    parameter int unsigned DIM_BITS = pnmhp_pkg::DIM_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pnmhp_pkg::in_beat_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pnmhp_pkg::out_beat_t out_data
);
    import pnmhp_pkg::*;

    // parse phases
    localparam logic [3:0] PH_MAGIC0     = 4'd0;
    localparam logic [3:0] PH_MAGIC1_OK  = 4'd1;
    localparam logic [3:0] PH_MAGIC1_BAD = 4'd2;
    localparam logic [3:0] PH_SKIP2      = 4'd3;
    localparam logic [3:0] PH_BYTE3      = 4'd4;
    localparam logic [3:0] PH_COMMENT1   = 4'd5;
    localparam logic [3:0] PH_DIMS       = 4'd6;
    localparam logic [3:0] PH_POST       = 4'd7;
    localparam logic [3:0] PH_COMMENT2   = 4'd8;
    localparam logic [3:0] PH_MAXVAL     = 4'd9;
    localparam logic [3:0] PH_DONE       = 4'd10;

    localparam int unsigned SUM_W = DIM_BITS + 4;
    localparam logic [DIM_BITS-1:0] DIM_MAX = {DIM_BITS{1'b1}};

    // state
    logic                format_kind_reg;
    logic [3:0]          phase_reg, phase_next;
    logic [DIM_BITS-1:0] width_acc_reg, width_acc_next;
    logic [DIM_BITS-1:0] height_acc_reg, height_acc_next;
    logic                width_closed_reg, width_closed_next;
    logic                past_space_reg, past_space_next;
    logic                height_closed_reg, height_closed_next;

    // output register and skid register
    logic      out_valid_reg;
    out_beat_t out_data_reg;
    logic      skid_valid_reg;
    out_beat_t skid_data_reg;

    // step signals
    logic                in_fire;
    logic                out_fire;
    logic [7:0]          b;
    logic                is_lf, is_hash, is_space, is_digit;
    logic [3:0]          digit_val;
    logic [3:0]          cur_phase;
    logic [DIM_BITS-1:0] cur_w, cur_h;
    logic                cur_wc, cur_ps, cur_hc;
    logic [SUM_W-1:0]    w_sum, h_sum;
    logic [DIM_BITS-1:0] w_sat, h_sat;
    logic                dims_en;
    logic                res_fire;
    out_beat_t           res_beat;
    logic [FIELD_W+DIM_BITS-1:0] w_ext, h_ext;
    logic [7:0]          magic_char;

    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // byte classification
    assign b         = in_data.byte_value;
    assign is_lf     = (b == CH_LF);
    assign is_hash   = (b == CH_HASH);
    assign is_space  = (b == CH_SPACE);
    assign is_digit  = (b >= CH_0) && (b <= CH_9);
    assign digit_val = b[3:0];
    assign magic_char = format_kind_reg ? CH_6 : CH_5;

    // frame start clears the parse before the byte is taken
    assign cur_phase = in_data.frame_start ? PH_MAGIC0 : phase_reg;
    assign cur_w     = in_data.frame_start ? '0 : width_acc_reg;
    assign cur_h     = in_data.frame_start ? '0 : height_acc_reg;
    assign cur_wc    = in_data.frame_start ? 1'b0 : width_closed_reg;
    assign cur_ps    = in_data.frame_start ? 1'b0 : past_space_reg;
    assign cur_hc    = in_data.frame_start ? 1'b0 : height_closed_reg;

    // decimal digit append with saturation
    assign w_sum = SUM_W'(cur_w) * SUM_W'(10) + SUM_W'(digit_val);
    assign h_sum = SUM_W'(cur_h) * SUM_W'(10) + SUM_W'(digit_val);
    assign w_sat = (w_sum > SUM_W'(DIM_MAX)) ? DIM_MAX : w_sum[DIM_BITS-1:0];
    assign h_sat = (h_sum > SUM_W'(DIM_MAX)) ? DIM_MAX : h_sum[DIM_BITS-1:0];

    // accumulators fit onto the result fields
    assign w_ext = {{FIELD_W{1'b0}}, cur_w};
    assign h_ext = {{FIELD_W{1'b0}}, cur_h};

    // dimension line byte
    assign dims_en = ((cur_phase == PH_BYTE3) && !is_hash) || (cur_phase == PH_DIMS);

    always_comb
    begin
        width_acc_next     = cur_w;
        height_acc_next    = cur_h;
        width_closed_next  = cur_wc;
        past_space_next    = cur_ps;
        height_closed_next = cur_hc;
        if (dims_en && !is_lf)
        begin
            if (!cur_ps)
            begin
                if (is_space)
                begin
                    past_space_next   = 1'b1;
                    width_closed_next = 1'b1;
                end
                else if (!cur_wc)
                begin
                    if (is_digit)
                        width_acc_next = w_sat;
                    else
                        width_closed_next = 1'b1;
                end
            end
            else if (!cur_hc)
            begin
                if (is_digit)
                    height_acc_next = h_sat;
                else
                    height_closed_next = 1'b1;
            end
        end
    end

    // phase sequencing and result generation
    always_comb
    begin
        phase_next      = cur_phase;
        res_fire        = 1'b0;
        res_beat.width  = w_ext[FIELD_W-1:0];
        res_beat.height = h_ext[FIELD_W-1:0];
        res_beat.status = ST_OK;
        unique case (cur_phase)
            PH_MAGIC0:
                phase_next = (b == CH_P) ? PH_MAGIC1_OK : PH_MAGIC1_BAD;
            PH_MAGIC1_OK, PH_MAGIC1_BAD:
            begin
                if ((cur_phase == PH_MAGIC1_BAD) || (b != magic_char))
                begin
                    res_fire        = 1'b1;
                    res_beat.width  = '0;
                    res_beat.height = '0;
                    res_beat.status = ST_MAGIC;
                    phase_next      = PH_DONE;
                end
                else
                begin
                    phase_next = PH_SKIP2;
                end
            end
            PH_SKIP2:
                phase_next = PH_BYTE3;
            PH_BYTE3:
            begin
                if (is_hash)
                    phase_next = PH_COMMENT1;
                else
                    phase_next = is_lf ? PH_POST : PH_DIMS;
            end
            PH_COMMENT1:
                if (is_lf) phase_next = PH_DIMS;
            PH_DIMS:
                if (is_lf) phase_next = PH_POST;
            PH_POST:
            begin
                if (is_hash)
                    phase_next = PH_COMMENT2;
                else if (is_lf)
                begin
                    res_fire   = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                    phase_next = PH_MAXVAL;
            end
            PH_COMMENT2:
                if (is_lf) phase_next = PH_MAXVAL;
            PH_MAXVAL:
            begin
                if (is_lf)
                begin
                    res_fire   = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            default:
                phase_next = PH_DONE;
        endcase
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            format_kind_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            format_kind_reg <= cfg_data;
    end

    // parse state update on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_MAGIC0;
            width_acc_reg     <= '0;
            height_acc_reg    <= '0;
            width_closed_reg  <= 1'b0;
            past_space_reg    <= 1'b0;
            height_closed_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg         <= phase_next;
            width_acc_reg     <= width_acc_next;
            height_acc_reg    <= height_acc_next;
            width_closed_reg  <= width_closed_next;
            past_space_reg    <= past_space_next;
            height_closed_reg <= height_closed_next;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_fire)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                    out_valid_reg <= in_fire && res_fire;
            end
            else if (in_fire && res_fire)
                skid_valid_reg <= 1'b1;
        end
    end

    // result payloads
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (in_fire && res_fire)
                out_data_reg <= res_beat;
        end
        else if (in_fire && res_fire)
            skid_data_reg <= res_beat;
    end

endmodule

[hdl/pnmhp_checker.sv]
// port-level checks for the netpbm header parser, bound to the top level
`include "pnm_header_parser_unit_macros.svh"

module pnmhp_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input pnmhp_pkg::out_beat_t out_data
);
    import pnmhp_pkg::*;

    logic err_beat;
    logic dims_zero;

    // error beat on the output and its dimension fields
    assign err_beat  = out_valid && (out_data.status == ST_MAGIC);
    assign dims_zero = (out_data.width == '0) && (out_data.height == '0);

    // a stalled result beat stays offered
    `PNMHP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // a magic error carries no dimensions
    `PNMHP_ASSERT_NOW(a_err_zero, err_beat, dims_zero)

    // input back-pressure only with a result waiting in the output register
    `PNMHP_ASSERT_NOW(a_stall_needs_out, in_stall, out_valid)

    // back-pressure starts only after a stalled result
    `PNMHP_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(out_valid && out_stall))

endmodule

bind pnm_header_parser_unit pnmhp_checker u_pnmhp_checker (.*);
